// File: hw/rtl/edge_trigger_hysteresis_interp_macros.svh
// Assertion helpers for the top-level file that checks this block.
`ifndef EDGE_TRIGGER_HYSTERESIS_INTERP_MACROS_SVH
`define EDGE_TRIGGER_HYSTERESIS_INTERP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETHI_ASSERT_SAME(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ethi check failed");

// The consequent must hold in the cycle after the antecedent.
`define ETHI_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ethi check failed");

`endif

// File: hw/rtl/ethi_pkg.sv
package ethi_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int HYST_W      = 15;
  localparam int STAMP_W     = 32;
  localparam int INDEX_W     = 12;
  localparam int PROD_W      = SAMPLE_W + STAMP_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEVEL  = 3'd0,
    REG_HYST   = 3'd1,
    REG_MODE   = 3'd2,
    REG_SOURCE = 3'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_RISING  = 2'd1,
    MODE_FALLING = 2'd2,
    MODE_ANY     = 2'd3
  } edge_mode_t;

  localparam logic signed [SAMPLE_W-1:0] LEVEL_RESET  = '0;
  localparam logic [HYST_W-1:0]          HYST_RESET   = 15'd400;
  localparam edge_mode_t                 MODE_RESET   = MODE_RISING;
  localparam logic                       SOURCE_RESET = 1'b0;

  typedef struct packed {
    logic                fired;
    logic [INDEX_W-1:0]  index;
    logic                interp;
    logic [STAMP_W-1:0]  stamp;
    logic [STAMP_W-1:0]  prev_stamp;
    logic [SAMPLE_W-1:0] num_mag;
    logic [SAMPLE_W-1:0] den_mag;
    logic                neg;
  } job_t;

  typedef struct packed {
    logic armed;
    logic done;
    logic at_start;
  } front_status_t;

endpackage

// File: hw/rtl/ethi_if.sv
interface ethi_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ethi_pkg::SAMPLE_W-1:0] chan0_sample;
  logic signed [ethi_pkg::SAMPLE_W-1:0] chan1_sample;
  logic [ethi_pkg::STAMP_W-1:0]         stamp;
  logic                                 buffer_end;

  modport source (output valid, chan0_sample, chan1_sample, stamp, buffer_end, input ready);
  modport sink (input valid, chan0_sample, chan1_sample, stamp, buffer_end, output ready);
endinterface

interface ethi_result_if;
  logic                         valid;
  logic                         ready;
  logic                         fired;
  logic [ethi_pkg::INDEX_W-1:0] fire_index;
  logic [ethi_pkg::STAMP_W-1:0] fire_time;

  modport source (output valid, fired, fire_index, fire_time, input ready);
  modport sink (input valid, fired, fire_index, fire_time, output ready);
endinterface

// File: hw/rtl/ethi_fifo.sv
module ethi_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ethi_pkg::job_t  wdata,
  output logic            full,
  input  logic            pop,
  output ethi_pkg::job_t  rdata,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  ethi_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: hw/rtl/ethi_front.sv
module ethi_front #(
  parameter int MAX_BUFFER = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ethi_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ethi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  ethi_sample_if.sink                         samples,
  input  logic                                queue_full,
  output logic                                push,
  output ethi_pkg::job_t                      job,
  output ethi_pkg::front_status_t             status
);

  localparam int POS_W = $clog2(MAX_BUFFER);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_BUFFER - 1);

  logic signed [ethi_pkg::SAMPLE_W-1:0] level;
  logic [ethi_pkg::HYST_W-1:0]          hyst;
  ethi_pkg::edge_mode_t                 mode;
  logic                                 source;
  logic                                 armed;
  logic signed [ethi_pkg::SAMPLE_W-1:0] prev_level;
  logic [ethi_pkg::STAMP_W-1:0]         prev_stamp;
  logic [POS_W-1:0]                     pos;
  logic                                 done;

  logic                                 accept;
  logic                                 cfg_hit;
  logic                                 active;
  logic signed [ethi_pkg::SAMPLE_W-1:0] cur;
  logic signed [ethi_pkg::SAMPLE_W:0]   level_x;
  logic signed [ethi_pkg::SAMPLE_W:0]   prev_x;
  logic signed [ethi_pkg::SAMPLE_W:0]   cur_x;
  logic signed [ethi_pkg::SAMPLE_W:0]   thr_lo;
  logic signed [ethi_pkg::SAMPLE_W:0]   thr_hi;
  logic signed [ethi_pkg::SAMPLE_W:0]   num;
  logic signed [ethi_pkg::SAMPLE_W:0]   den;
  logic                                 cur_ge;
  logic                                 prev_ge;
  logic                                 arm_set;
  logic                                 fire;
  logic                                 armed_next;
  logic [31:0]                          pos_wide;

  assign samples.ready = !queue_full && !cfg_we;
  assign accept        = samples.valid && samples.ready;
  assign active        = accept && !done && (mode != ethi_pkg::MODE_NONE);

  assign cur     = source ? samples.chan1_sample : samples.chan0_sample;
  assign level_x = {level[ethi_pkg::SAMPLE_W-1], level};
  assign prev_x  = {prev_level[ethi_pkg::SAMPLE_W-1], prev_level};
  assign cur_x   = {cur[ethi_pkg::SAMPLE_W-1], cur};
  assign thr_lo  = level_x - $signed({2'b00, hyst});
  assign thr_hi  = level_x + $signed({2'b00, hyst});
  assign num     = level_x - prev_x;
  assign den     = cur_x - prev_x;
  assign cur_ge  = cur >= level;
  assign prev_ge = prev_level >= level;

  always_comb begin
    arm_set    = armed;
    fire       = 1'b0;
    armed_next = armed;
    unique case (mode)
      ethi_pkg::MODE_NONE: begin
        fire = 1'b0;
      end
      ethi_pkg::MODE_RISING: begin
        arm_set    = armed || (cur_x < thr_lo);
        fire       = arm_set && cur_ge;
        armed_next = arm_set && !fire;
      end
      ethi_pkg::MODE_FALLING: begin
        arm_set    = armed || (cur_x > thr_hi);
        fire       = arm_set && (cur <= level);
        armed_next = arm_set && !fire;
      end
      ethi_pkg::MODE_ANY: begin
        fire = prev_ge != cur_ge;
      end
    endcase
  end

  always_comb begin
    unique case (ethi_pkg::cfg_reg_t'(cfg_index))
      ethi_pkg::REG_LEVEL,
      ethi_pkg::REG_HYST,
      ethi_pkg::REG_MODE,
      ethi_pkg::REG_SOURCE: cfg_hit = 1'b1;
      default:              cfg_hit = 1'b0;
    endcase
  end

  assign pos_wide = 32'(pos);

  always_comb begin
    job            = '0;
    job.fired      = fire;
    job.index      = fire ? pos_wide[ethi_pkg::INDEX_W-1:0] : '0;
    job.interp     = fire && (pos != '0) && (prev_level != cur);
    job.stamp      = fire ? samples.stamp : '0;
    job.prev_stamp = prev_stamp;
    job.num_mag    = num[ethi_pkg::SAMPLE_W] ? ethi_pkg::SAMPLE_W'(-num)
                                             : num[ethi_pkg::SAMPLE_W-1:0];
    job.den_mag    = den[ethi_pkg::SAMPLE_W] ? ethi_pkg::SAMPLE_W'(-den)
                                             : den[ethi_pkg::SAMPLE_W-1:0];
    job.neg        = (num[ethi_pkg::SAMPLE_W] != den[ethi_pkg::SAMPLE_W]) && (num != '0);
  end

  assign push = accept && !done && samples.buffer_end && (mode == ethi_pkg::MODE_NONE)
             || active && (fire || samples.buffer_end);

  assign status.armed    = armed;
  assign status.done     = done;
  assign status.at_start = (pos == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= ethi_pkg::LEVEL_RESET;
      hyst       <= ethi_pkg::HYST_RESET;
      mode       <= ethi_pkg::MODE_RESET;
      source     <= ethi_pkg::SOURCE_RESET;
      armed      <= 1'b0;
      prev_level <= '0;
      pos        <= '0;
      done       <= 1'b0;
    end else if (cfg_we) begin
      unique case (ethi_pkg::cfg_reg_t'(cfg_index))
        ethi_pkg::REG_LEVEL:  level  <= $signed(cfg_wdata);
        ethi_pkg::REG_HYST:   hyst   <= cfg_wdata[ethi_pkg::HYST_W-1:0];
        ethi_pkg::REG_MODE:   mode   <= ethi_pkg::edge_mode_t'(cfg_wdata[1:0]);
        ethi_pkg::REG_SOURCE: source <= cfg_wdata[0];
        default: begin
        end
      endcase
      if (cfg_hit) begin
        armed      <= 1'b0;
        prev_level <= '0;
      end
    end else if (accept) begin
      if (done) begin
        if (samples.buffer_end) begin
          done <= 1'b0;
          pos  <= '0;
        end
      end else if (mode == ethi_pkg::MODE_NONE) begin
        if (samples.buffer_end) begin
          pos <= '0;
        end
      end else begin
        armed      <= armed_next;
        prev_level <= cur;
        if (fire && !samples.buffer_end) begin
          done <= 1'b1;
        end else if (samples.buffer_end) begin
          pos <= '0;
        end else if (pos != POS_LAST) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      prev_stamp <= samples.stamp;
    end
  end

endmodule

// File: hw/rtl/ethi_back.sv
module ethi_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  ethi_pkg::job_t rdata,
  output logic           pop,
  ethi_result_if.source  results
);

  localparam int PW    = ethi_pkg::PROD_W;
  localparam int SW    = ethi_pkg::SAMPLE_W;
  localparam int TW    = ethi_pkg::STAMP_W;
  localparam int CNT_W = $clog2(PW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PW - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t                   state;
  ethi_pkg::job_t           job;
  logic [PW-1:0]            prod;
  logic [SW-1:0]            rem;
  logic [CNT_W-1:0]         cnt;
  logic                     out_valid;
  logic                     out_fired;
  logic [ethi_pkg::INDEX_W-1:0] out_index;
  logic [TW-1:0]            out_time;

  logic                     slot_free;
  logic                     out_load;
  logic [SW:0]              rem_sh;
  logic [SW:0]              diff;
  logic                     qbit;
  logic [TW-1:0]            dt;
  logic [TW-1:0]            quot;
  logic [TW-1:0]            result_time;

  assign results.valid      = out_valid;
  assign results.fired      = out_fired;
  assign results.fire_index = out_index;
  assign results.fire_time  = out_time;

  assign slot_free = !out_valid || results.ready;
  assign pop       = (state == S_IDLE) && !empty && (rdata.interp || slot_free);
  assign out_load  = (pop && !rdata.interp) || ((state == S_DONE) && slot_free);

  assign rem_sh      = {rem, prod[PW-1]};
  assign diff        = rem_sh - {1'b0, job.den_mag};
  assign qbit        = rem_sh >= {1'b0, job.den_mag};
  assign dt          = job.stamp - job.prev_stamp;
  assign quot        = prod[TW-1:0];
  assign result_time = job.neg ? job.prev_stamp - quot : job.prev_stamp + quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            job <= rdata;
            if (rdata.interp) begin
              state <= S_MUL;
            end else begin
              out_valid <= 1'b1;
              out_fired <= rdata.fired;
              out_index <= rdata.index;
              out_time  <= rdata.stamp;
            end
          end
        end
        S_MUL: begin
          prod  <= PW'(job.num_mag) * PW'(dt);
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          prod <= {prod[PW-2:0], qbit};
          rem  <= qbit ? diff[SW-1:0] : rem_sh[SW-1:0];
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_fired <= 1'b1;
            out_index <= job.index;
            out_time  <= result_time;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/edge_trigger_hysteresis_interp.sv
// Edge trigger with hysteresis and sub-sample time interpolation.
// The samples channel takes one two-channel sample per transaction, with a
// timestamp and a mark on the last sample of each buffer. The results channel
// gives one transaction per buffer: whether the trigger fired, the position
// of the firing sample and the trigger time. Configuration registers are
// written through cfg_we, cfg_index and cfg_wdata; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// The front stage accepts one sample per cycle whenever the result queue has
// room and no configuration write is under way. A result that needs no
// interpolation passes through the queue into the output register. An
// interpolated fire passes through the queue, the 16 by 32 bit product, the
// bit-serial divider and the output register; the queue keeps taking samples
// meanwhile as long as it has room.
// When the receiver stalls, the output register holds its result, the queue
// fills, and the samples channel then drops ready.
// Reset restores the register defaults and clears the trigger state, the
// queue and the output register; there is no clearing pass.
module edge_trigger_hysteresis_interp #(
  parameter int MAX_BUFFER  = 4096,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ethi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ethi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ethi_sample_if.sink                      samples,
  ethi_result_if.source                    results
);

  `include "edge_trigger_hysteresis_interp_macros.svh"

  ethi_pkg::job_t          push_job;
  ethi_pkg::job_t          pop_job;
  ethi_pkg::front_status_t status;
  logic                    push;
  logic                    pop;
  logic                    queue_full;
  logic                    queue_empty;

  ethi_front #(
    .MAX_BUFFER(MAX_BUFFER)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .samples   (samples),
    .queue_full(queue_full),
    .push      (push),
    .job       (push_job),
    .status    (status)
  );

  ethi_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(push_job),
    .full (queue_full),
    .pop  (pop),
    .rdata(pop_job),
    .empty(queue_empty)
  );

  ethi_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (queue_empty),
    .rdata  (pop_job),
    .pop    (pop),
    .results(results)
  );

  `ETHI_ASSERT_NEXT(a_cfg_disarms, clk, rst,
    cfg_we && (cfg_index <= ethi_pkg::CFG_INDEX_W'(ethi_pkg::REG_SOURCE)), !status.armed)
  `ETHI_ASSERT_NEXT(a_buffer_end_rewinds, clk, rst,
    samples.valid && samples.ready && samples.buffer_end, status.at_start && !status.done)
  `ETHI_ASSERT_SAME(a_no_fire_is_zero, clk, rst,
    results.valid && !results.fired, (results.fire_index == '0) && (results.fire_time == '0))

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_BUFFER = 4096;
  localparam int LATENCY_PAD = 80;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 72;
  localparam logic [ethi_pkg::CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic signed [ethi_pkg::SAMPLE_W-1:0] chan0;
    logic signed [ethi_pkg::SAMPLE_W-1:0] chan1;
    logic [ethi_pkg::STAMP_W-1:0]         stamp;
    logic                                 fin;
  } sample_t;

  typedef struct packed {
    logic                         fired;
    logic [ethi_pkg::INDEX_W-1:0] index;
    logic [ethi_pkg::STAMP_W-1:0] trig_time;
  } outcome_t;

  typedef enum {DEEP, BAND, OVER, EXACT, WILD} wave_kind_t;

  class trigger_scoreboard;
    logic signed [ethi_pkg::SAMPLE_W-1:0] level;
    logic [ethi_pkg::HYST_W-1:0]          hyst;
    ethi_pkg::edge_mode_t                 mode;
    logic                                 watch_ch1;
    logic                                 armed;
    logic signed [ethi_pkg::SAMPLE_W-1:0] prev;
    logic [ethi_pkg::STAMP_W-1:0]         prev_stamp;
    int                                   pos;
    logic                                 in_done;
    outcome_t                             expected[$];
    int errors, checked, fires, samples, buffers, settings;

    function new();
      level = ethi_pkg::LEVEL_RESET;
      hyst = ethi_pkg::HYST_RESET;
      mode = ethi_pkg::MODE_RESET;
      watch_ch1 = ethi_pkg::SOURCE_RESET;
      armed = 1'b0;
      prev = '0;
      prev_stamp = '0;
      pos = 0;
      in_done = 1'b0;
      errors = 0;
      checked = 0;
      fires = 0;
      samples = 0;
      buffers = 0;
      settings = 1;
    endfunction

    function void set_register(logic [ethi_pkg::CFG_INDEX_W-1:0] idx,
                               logic [ethi_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ethi_pkg::REG_LEVEL: level = data;
        ethi_pkg::REG_HYST: hyst = data[ethi_pkg::HYST_W-1:0];
        ethi_pkg::REG_MODE: mode = ethi_pkg::edge_mode_t'(data[1:0]);
        ethi_pkg::REG_SOURCE: watch_ch1 = data[0];
        default: return;
      endcase
      armed = 1'b0;
      prev = '0;
    endfunction

    function logic [ethi_pkg::STAMP_W-1:0] crossing_time(int cur,
                                                         logic [ethi_pkg::STAMP_W-1:0] stamp);
      int num, den, lv, p;
      logic [ethi_pkg::STAMP_W-1:0] dt;
      longint unsigned an, ad, q;
      lv = level;
      p = prev;
      num = lv - p;
      den = cur - p;
      dt = stamp - prev_stamp;
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = (an * dt) / ad;
      if (((num < 0) != (den < 0)) && num != 0)
        return prev_stamp - q[ethi_pkg::STAMP_W-1:0];
      return prev_stamp + q[ethi_pkg::STAMP_W-1:0];
    endfunction

    function void note_sample(sample_t s);
      logic signed [ethi_pkg::SAMPLE_W-1:0] cur;
      int c, lv, hy, p;
      logic fire;
      logic [ethi_pkg::STAMP_W-1:0] t;
      cur = watch_ch1 ? s.chan1 : s.chan0;
      c = cur;
      lv = level;
      hy = hyst;
      p = prev;
      fire = 1'b0;
      samples++;
      if (s.fin) buffers++;
      if (in_done) begin
        if (s.fin) begin
          in_done = 1'b0;
          pos = 0;
        end
        return;
      end
      if (mode == ethi_pkg::MODE_NONE) begin
        if (s.fin) begin
          expected.push_back('0);
          pos = 0;
        end
        return;
      end
      case (mode)
        ethi_pkg::MODE_RISING: begin
          if (!armed && c < lv - hy) armed = 1'b1;
          if (armed && c >= lv) begin
            fire = 1'b1;
            armed = 1'b0;
          end
        end
        ethi_pkg::MODE_FALLING: begin
          if (!armed && c > lv + hy) armed = 1'b1;
          if (armed && c <= lv) begin
            fire = 1'b1;
            armed = 1'b0;
          end
        end
        default: fire = (p >= lv) != (c >= lv);
      endcase
      if (fire) begin
        t = s.stamp;
        if (pos > 0 && prev != cur) t = crossing_time(c, s.stamp);
        expected.push_back('{1'b1, ethi_pkg::INDEX_W'(pos), t});
        prev = cur;
        prev_stamp = s.stamp;
        if (s.fin) pos = 0;
        else in_done = 1'b1;
        return;
      end
      prev = cur;
      prev_stamp = s.stamp;
      if (s.fin) begin
        expected.push_back('0);
        pos = 0;
      end else if (pos < MAX_BUFFER - 1) begin
        pos++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      checked++;
      if (got.fired) fires++;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result fired=%0b index=%0d time=%0h",
                   got.fired, got.index, got.trig_time);
        return;
      end
      want = expected.pop_front();
      if (got.fired !== want.fired || got.index !== want.index ||
          got.trig_time !== want.trig_time) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: expected fired=%0b index=%0d time=%0h, got fired=%0b index=%0d time=%0h",
                   want.fired, want.index, want.trig_time,
                   got.fired, got.index, got.trig_time);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [ethi_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ethi_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ethi_sample_if smp();
  ethi_result_if res();

  trigger_scoreboard sb;
  int src_idle;
  int snk_idle;
  logic calm;

  edge_trigger_hysteresis_interp DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .samples(smp),
    .results(res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    res.ready <= calm || ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_result('{res.fired, res.fire_index, res.fire_time});
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((smp.valid && smp.ready) || (res.valid && res.ready)) quiet = 0;
      else quiet++;
    end
    $display("No transaction for %0d cycles.", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_sample(input logic signed [ethi_pkg::SAMPLE_W-1:0] c0,
                             input logic signed [ethi_pkg::SAMPLE_W-1:0] c1,
                             input logic [ethi_pkg::STAMP_W-1:0] st, input logic fin);
    sample_t s;
    s = '{c0, c1, st, fin};
    while (!calm && $urandom_range(99) < src_idle) begin
      smp.valid <= 1'b0;
      @(negedge clk);
    end
    smp.valid <= 1'b1;
    smp.chan0_sample <= c0;
    smp.chan1_sample <= c1;
    smp.stamp <= st;
    smp.buffer_end <= fin;
    @(posedge clk);
    while (smp.ready !== 1'b1) @(posedge clk);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [ethi_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ethi_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic settle();
    smp.valid <= 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (LATENCY_PAD) @(negedge clk);
  endtask

  function automatic logic signed [ethi_pkg::SAMPLE_W-1:0] watched_value(wave_kind_t k);
    int lv, hy, dir, r, v;
    lv = sb.level;
    hy = sb.hyst;
    dir = (sb.mode == ethi_pkg::MODE_FALLING) ? 1 : -1;
    r = ($urandom_range(7) == 0) ? $urandom_range(40000) : $urandom_range(300);
    case (k)
      DEEP: v = lv + dir * (hy + 1 + r);
      BAND: begin
        r = (hy == 0) ? 0 : $urandom_range(hy, 1);
        v = lv + dir * r;
      end
      OVER: v = lv - dir * r;
      EXACT: begin
        r = $urandom_range(2);
        v = (r == 0) ? lv : (r == 1) ? lv + dir * hy : lv + dir * (hy + 1);
      end
      default: begin
        r = $urandom_range(65535);
        v = r - 32768;
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return ethi_pkg::SAMPLE_W'(v);
  endfunction

  task automatic run_buffers(input int n);
    wave_kind_t plan[$];
    logic [ethi_pkg::STAMP_W-1:0] st;
    logic signed [ethi_pkg::SAMPLE_W-1:0] w, o;
    int sent, i, r;
    sent = 0;
    while (sent < n) begin
      plan.delete();
      calm = ($urandom_range(5) == 0);
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(12, 1)) plan.push_back(wave_kind_t'($urandom_range(4)));
      end else begin
        repeat ($urandom_range(3)) plan.push_back($urandom_range(1) ? BAND : OVER);
        repeat ($urandom_range(3, 1)) plan.push_back(DEEP);
        repeat ($urandom_range(2)) plan.push_back(BAND);
        plan.push_back(($urandom_range(3) == 0) ? EXACT : OVER);
        repeat ($urandom_range(($urandom_range(9) == 0) ? 40 : 4))
          plan.push_back(wave_kind_t'($urandom_range(4)));
      end
      st = ($urandom_range(7) == 0) ? 32'hFFFF_FF80 + $urandom_range(127) : $urandom;
      for (i = 0; i < plan.size(); i++) begin
        w = watched_value(plan[i]);
        o = ethi_pkg::SAMPLE_W'($urandom);
        if (sb.watch_ch1) send_sample(o, w, st, i == plan.size() - 1);
        else send_sample(w, o, st, i == plan.size() - 1);
        r = $urandom_range(31);
        if (r == 0) st = st;
        else if (r == 1) st = $urandom;
        else st = st + $urandom_range(100, 1);
      end
      sent += plan.size();
    end
    calm = 1'b0;
  endtask

  task automatic run_phase(input logic signed [ethi_pkg::SAMPLE_W-1:0] lv,
                           input logic [ethi_pkg::HYST_W-1:0] hy,
                           input ethi_pkg::edge_mode_t md, input logic ch, input int n);
    settle();
    write_reg(ethi_pkg::REG_LEVEL, lv);
    write_reg(ethi_pkg::REG_HYST, {1'($urandom), hy});
    write_reg(ethi_pkg::REG_MODE, {14'($urandom), md});
    write_reg(ethi_pkg::REG_SOURCE, {15'($urandom), ch});
    if ($urandom_range(1)) write_reg(REG_SPARE, ethi_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    sb.settings++;
    run_buffers(n);
  endtask

  initial begin : stimulus
    sb = new();
    calm = 1'b0;
    src_idle = 13;
    snk_idle = 61;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    smp.valid = 1'b0;
    smp.chan0_sample = '0;
    smp.chan1_sample = '0;
    smp.stamp = '0;
    smp.buffer_end = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Rising edge at reset settings: arm, interpolated fire, rest of buffer ignored.
    send_sample(-16'sd500, 16'sh7FFF, 32'd1000, 1'b0);
    send_sample(16'sd100, 16'sh8000, 32'd1010, 1'b0);
    send_sample(16'sd30000, 16'sd0, 32'd1020, 1'b0);
    send_sample(-16'sd30000, 16'sd0, 32'd1030, 1'b1);
    // Fire across a timestamp wrap.
    send_sample(16'sh8000, -16'sd1, 32'hFFFF_FFF0, 1'b0);
    send_sample(-16'sd401, 16'sd0, 32'hFFFF_FFF8, 1'b0);
    send_sample(16'sh7FFF, 16'sd0, 32'h0000_0008, 1'b1);
    // Arm in one buffer, fire on the first sample of the next.
    send_sample(-16'sd1000, 16'sd0, 32'd0, 1'b1);
    send_sample(16'sd0, 16'sd0, 32'hFFFF_FFFF, 1'b1);
    // Exactly at the arming threshold: no arm and no fire.
    send_sample(-16'sd400, 16'sd0, 32'd5, 1'b0);
    send_sample(-16'sd1, 16'sd0, 32'd6, 1'b0);
    send_sample(16'sd5, 16'sd0, 32'd7, 1'b1);

    settle();
    write_reg(ethi_pkg::REG_SOURCE, 16'hFFFF);
    write_reg(ethi_pkg::REG_MODE, 16'hFFFF);
    write_reg(REG_SPARE, 16'hFFFF);
    cfg_we <= 1'b0;
    sb.settings++;
    send_sample(16'sd77, -16'sd5, 32'd100, 1'b0);
    send_sample(16'sd0, 16'sd7, 32'd110, 1'b1);
    send_sample(-16'sd77, -16'sd3, 32'd200, 1'b0);
    send_sample(16'sd0, 16'sd9, 32'd210, 1'b0);
    send_sample(16'sd0, 16'sd0, 32'd220, 1'b1);

    settle();
    write_reg(ethi_pkg::REG_MODE, 16'hFFFC);
    cfg_we <= 1'b0;
    sb.settings++;
    send_sample(16'sd1, 16'sd1, 32'd1, 1'b0);
    send_sample(16'sd2, 16'sd2, 32'd2, 1'b1);

    run_phase(16'sd0, 15'd400, ethi_pkg::MODE_RISING, 1'b0, PHASE_ITEMS);
    run_phase(16'sh7FFF, 15'd0, ethi_pkg::MODE_FALLING, 1'b1, PHASE_ITEMS);
    run_phase(16'sh8000, 15'h7FFF, ethi_pkg::MODE_RISING, 1'b0, PHASE_ITEMS);
    src_idle = 61;
    snk_idle = 13;
    run_phase(ethi_pkg::SAMPLE_W'($urandom), ethi_pkg::HYST_W'($urandom_range(600)),
              ethi_pkg::MODE_ANY, 1'b1, PHASE_ITEMS);
    run_phase(16'sd1234, 15'h7FFF, ethi_pkg::MODE_FALLING, 1'b0, PHASE_ITEMS);
    run_phase(-16'sd200, 15'd50, ethi_pkg::MODE_NONE, 1'b1, PHASE_ITEMS);
    src_idle = 0;
    snk_idle = 0;
    run_phase(ethi_pkg::SAMPLE_W'($urandom), ethi_pkg::HYST_W'($urandom),
              ethi_pkg::MODE_RISING, 1'b1, PHASE_ITEMS);
    run_phase(16'sd300, 15'd0, ethi_pkg::MODE_ANY, 1'b0, PHASE_ITEMS);
    run_phase(ethi_pkg::SAMPLE_W'($urandom), ethi_pkg::HYST_W'($urandom_range(2000)),
              ethi_pkg::edge_mode_t'($urandom_range(3)), 1'($urandom), PHASE_ITEMS);

    settle();
    $display("Covered %0d samples in %0d buffers over %0d register settings.",
             sb.samples, sb.buffers, sb.settings);
    $display("Checked %0d results, %0d with the trigger fired; %0d mismatches.",
             sb.checked, sb.fires, sb.errors);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: edge_trigger_hysteresis_interp.f
+incdir+hw/rtl
hw/rtl/ethi_pkg.sv
hw/rtl/ethi_if.sv
hw/rtl/ethi_fifo.sv
hw/rtl/ethi_front.sv
hw/rtl/ethi_back.sv
hw/rtl/edge_trigger_hysteresis_interp.sv
verif/tb_top.sv
